// ===== hw/rtl/fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the flux stream decoder.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // stream opcodes
  localparam logic [7:0] OP_F2_MAX = 8'h07;
  localparam logic [7:0] OP_NOP    = 8'h08;
  localparam logic [7:0] OP_SKIP1  = 8'h09;
  localparam logic [7:0] OP_SKIP2  = 8'h0a;
  localparam logic [7:0] OP_OVL    = 8'h0b;
  localparam logic [7:0] OP_F3     = 8'h0c;
  localparam logic [7:0] OP_OOB    = 8'h0d;
  localparam logic [7:0] OP_F1_MIN = 8'h0e;

  localparam logic [31:0] OVL_STEP = 32'h0001_0000;

  // 12 MHz over the 24.027 MHz sample clock, Q8.24
  localparam logic [31:0] TICK_SCALE_RESET = 32'd8379028;

  // queue between parser and scaler
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef struct packed {
    logic        vld;
    logic [31:0] sclk;
  } flux_word_t;

endpackage

// ===== hw/rtl/fsd_front.sv =====
// ----------------------------------------------------------------------------
// fsd_front
// Stream parser: decodes opcodes and multi-byte values, tracks overflow and
// out-of-band blocks, and hands finished intervals to the queue.
// ----------------------------------------------------------------------------
module fsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          byte_i,
  output fsd_pkg::flux_word_t emit_o
);

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_F2_LO    = 10'b00_0000_0010,
    PH_F3_HI    = 10'b00_0000_0100,
    PH_F3_LO    = 10'b00_0000_1000,
    PH_SKIP2    = 10'b00_0001_0000,
    PH_SKIP1    = 10'b00_0010_0000,
    PH_OOB_TYPE = 10'b00_0100_0000,
    PH_OOB_LLO  = 10'b00_1000_0000,
    PH_OOB_LHI  = 10'b01_0000_0000,
    PH_OOB_DATA = 10'b10_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] oob_rem_q, oob_rem_d;
  logic [7:0]  oob_llo_q, oob_llo_d;
  logic [31:0] ovf_q, ovf_d;

  logic        emit;
  logic [15:0] value;
  logic [32:0] sum;
  logic [32:0] ovf_sum;
  logic [15:0] rem_dec;

  assign sum     = {1'b0, ovf_q} + {17'b0, value};
  assign ovf_sum = {1'b0, ovf_q} + {1'b0, fsd_pkg::OVL_STEP};
  assign rem_dec = oob_rem_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    high_d    = high_q;
    oob_rem_d = oob_rem_q;
    oob_llo_d = oob_llo_q;
    ovf_d     = ovf_q;
    emit      = 1'b0;
    value     = {high_q, byte_i};
    if (acc_i) begin
      case (phase_q)
        PH_F2_LO, PH_F3_LO: begin
          phase_d = PH_IDLE;
          emit    = 1'b1;
        end
        PH_F3_HI: begin
          high_d  = byte_i;
          phase_d = PH_F3_LO;
        end
        PH_SKIP2:    phase_d = PH_SKIP1;
        PH_SKIP1:    phase_d = PH_IDLE;
        PH_OOB_TYPE: phase_d = PH_OOB_LLO;
        PH_OOB_LLO: begin
          oob_llo_d = byte_i;
          phase_d   = PH_OOB_LHI;
        end
        PH_OOB_LHI: begin
          oob_rem_d = {byte_i, oob_llo_q};
          phase_d   = ({byte_i, oob_llo_q} != 16'd0) ? PH_OOB_DATA : PH_IDLE;
        end
        PH_OOB_DATA: begin
          oob_rem_d = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // idle, and any stray code: byte is an opcode
          phase_d = PH_IDLE;
          value   = {8'b0, byte_i};
          if (byte_i >= fsd_pkg::OP_F1_MIN) begin
            emit = 1'b1;
          end else if (byte_i <= fsd_pkg::OP_F2_MAX) begin
            high_d  = byte_i;
            phase_d = PH_F2_LO;
          end else if (byte_i == fsd_pkg::OP_SKIP1) begin
            phase_d = PH_SKIP1;
          end else if (byte_i == fsd_pkg::OP_SKIP2) begin
            phase_d = PH_SKIP2;
          end else if (byte_i == fsd_pkg::OP_OVL) begin
            ovf_d = ovf_sum[32] ? '1 : ovf_sum[31:0];
          end else if (byte_i == fsd_pkg::OP_F3) begin
            phase_d = PH_F3_HI;
          end else if (byte_i == fsd_pkg::OP_OOB) begin
            phase_d = PH_OOB_TYPE;
          end
          // OP_NOP: nothing to do
        end
      endcase
      if (emit) begin
        ovf_d = '0;
      end
    end
  end

  assign emit_o.vld  = emit;
  assign emit_o.sclk = sum[32] ? '1 : sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      high_q    <= '0;
      oob_rem_q <= '0;
      oob_llo_q <= '0;
      ovf_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      high_q    <= high_d;
      oob_rem_q <= oob_rem_d;
      oob_llo_q <= oob_llo_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ===== hw/rtl/fsd_queue.sv =====
// ----------------------------------------------------------------------------
// fsd_queue
// Short word queue between parser and scaler.
// ----------------------------------------------------------------------------
module fsd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsd_pkg::flux_word_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output fsd_pkg::flux_word_t head_o
);

  logic [31:0]                   mem_q [fsd_pkg::QUEUE_DEPTH];
  logic [fsd_pkg::QUEUE_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [fsd_pkg::QUEUE_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fsd_pkg::QUEUE_CW-1:0]  cnt_q, cnt_d;
  logic                          do_pop;

  assign full_o      = (cnt_q == fsd_pkg::QUEUE_CW'(fsd_pkg::QUEUE_DEPTH));
  assign head_o.vld  = (cnt_q != '0);
  assign head_o.sclk = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && head_o.vld;

  always_comb begin
    wr_ptr_d = push_i.vld ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.vld && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i.vld && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld) begin
      mem_q[wr_ptr_q] <= push_i.sclk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/fsd_back.sv =====
// ----------------------------------------------------------------------------
// fsd_back
// Tick scaler: multiplies each interval by the scale, shifts out the
// fraction, saturates, and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module fsd_back #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fsd_pkg::flux_word_t head_i,
  input  logic [31:0]         tick_scale_i,
  input  logic                pop_i,
  output logic                q_pop_o,
  output logic                empty_o,
  output logic [31:0]         ticks_o,
  output logic [31:0]         sclk_o
);

  logic        s1_vld_q;
  logic [63:0] s1_prod_q;
  logic [31:0] s1_sclk_q;
  logic        out_vld_q;
  logic [31:0] out_ticks_q;
  logic [31:0] out_sclk_q;

  logic        out_rdy;
  logic        s1_rdy;
  logic [63:0] shifted;
  logic [31:0] ticks;

  assign out_rdy = !out_vld_q || pop_i;
  assign s1_rdy  = !s1_vld_q || out_rdy;
  assign q_pop_o = head_i.vld && s1_rdy;

  assign shifted = s1_prod_q >> SCALE_FRAC_BITS;
  assign ticks   = (shifted[63:32] != '0) ? '1 : shifted[31:0];

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_prod_q <= 64'(head_i.sclk) * 64'(tick_scale_i);
      s1_sclk_q <= head_i.sclk;
    end
    if (out_rdy && s1_vld_q) begin
      out_ticks_q <= ticks;
      out_sclk_q  <= s1_sclk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_q <= head_i.vld;
      end
      if (out_rdy) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  assign empty_o = !out_vld_q;
  assign ticks_o = out_ticks_q;
  assign sclk_o  = out_sclk_q;

endmodule

// ===== hw/rtl/flux_stream_decoder_core.sv =====
// Throughput: one stream byte per cycle while full is low, one result word per
//   cycle while pop takes them. Path of an interval: the last byte goes into a
//   queue slot, then the 32x32 product is registered, then the scaled ticks.
// full_o rises only when the 4-word parser/scaler queue backs up behind pop_i.
// Reset (rst_ni low, async): parser idle, overflow clear, queues empty,
//   scale back to its reset value.
// ----------------------------------------------------------------------------
// flux_stream_decoder_core
// Flux stream byte decoder with interval scaling to output ticks.
// ----------------------------------------------------------------------------
module flux_stream_decoder_core #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] interval_ticks_o,
  output logic [31:0] interval_sclk_o,
  input  logic        tick_scale_q24_we_i,
  input  logic [31:0] tick_scale_q24_i
);

  logic                acc;
  logic                q_pop;
  fsd_pkg::flux_word_t emit;
  fsd_pkg::flux_word_t head;
  logic [31:0]         tick_scale_q24_q;

  assign acc = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_scale_q24_q <= fsd_pkg::TICK_SCALE_RESET;
    end else if (tick_scale_q24_we_i) begin
      tick_scale_q24_q <= tick_scale_q24_i;
    end
  end

  fsd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .byte_i (stream_byte_i),
    .emit_o (emit)
  );

  fsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .pop_i  (q_pop),
    .full_o (full),
    .head_o (head)
  );

  fsd_back #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .tick_scale_i (tick_scale_q24_q),
    .pop_i        (pop),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .ticks_o      (interval_ticks_o),
    .sclk_o       (interval_sclk_o)
  );

endmodule

// ===== hw/rtl/fsd_checker.sv =====
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the flux stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] interval_ticks_i,
  input logic [31:0] interval_sclk_i
);

  logic acc;
  assign acc = push && !full;

  // reset leaves nothing to read and room to write
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("reset did not clear both queues");

  // a waiting word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(interval_ticks_i) && $stable(interval_sclk_i)))
    else $error("result word changed while stalled");

  // full only rises after a word went in
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !acc) |=> !full)
    else $error("full rose without an accepted word");

  // pipeline drained: no result without fresh input
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(empty, 2) && $past(empty, 1) && empty &&
     !$past(acc, 2) && !$past(acc, 1)) |=> empty)
    else $error("result appeared with no input behind it");

endmodule

bind flux_stream_decoder_core fsd_checker u_fsd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .interval_ticks_i (interval_ticks_o),
  .interval_sclk_i  (interval_sclk_o)
);
